// ----- hw/rtl/jsu_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the JSON string unescaper.
package jsu_pkg;

	typedef enum logic [2:0] {
		M_EXPECT   = 3'd0,
		M_STR      = 3'd1,
		M_ESC      = 3'd2,
		M_HEX      = 3'd3,
		M_PAIR_BS  = 3'd4,
		M_PAIR_U   = 3'd5,
		M_PAIR_HEX = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NOT_STRING = 2'd1,
		ST_BAD_ESCAPE = 2'd2,
		ST_UNCLOSED   = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       carries_byte;
		logic       run_last;
		status_t    status;
	} result_t;

	localparam int unsigned MaxResults = 5;
	localparam int unsigned CntW       = $clog2(MaxResults + 1);
	localparam int unsigned IdxW       = $clog2(MaxResults);

	typedef result_t [MaxResults-1:0] result_list_t;

	localparam logic [15:0] SurHighLo = 16'hD800;
	localparam logic [15:0] SurHighHi = 16'hDBFF;
	localparam logic [15:0] SurLowLo  = 16'hDC00;
	localparam logic [15:0] SurLowHi  = 16'hDFFF;
	localparam logic [15:0] ReplChar  = 16'hFFFD;
	localparam logic [20:0] SuppBase  = 21'h10000;
	localparam logic [7:0]  Lead2     = 8'hC0;
	localparam logic [7:0]  Lead3     = 8'hE0;
	localparam logic [7:0]  Lead4     = 8'hF0;
	localparam logic [7:0]  ContMark  = 8'h80;

	localparam logic [7:0] ChQuote  = 8'h22;
	localparam logic [7:0] ChBslash = 8'h5C;
	localparam logic [7:0] ChSlash  = 8'h2F;
	localparam logic [7:0] ChLowU   = 8'h75;
	localparam logic [7:0] ChLowN   = 8'h6E;
	localparam logic [7:0] ChLowR   = 8'h72;
	localparam logic [7:0] ChLowT   = 8'h74;
	localparam logic [7:0] ChLowB   = 8'h62;
	localparam logic [7:0] ChLowF   = 8'h66;

	typedef struct packed {
		logic [1:0] len;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
	} bmp_utf8_t;

	// Returns {valid, value} for an ASCII hex digit.
	function automatic logic [4:0] hex_digit(logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	// Returns {valid, character} for a single-character escape.
	function automatic logic [8:0] esc_char(logic [7:0] c);
		logic [8:0] r;
		r = '0;
		unique case (c)
			ChQuote:  r = {1'b1, ChQuote};
			ChBslash: r = {1'b1, ChBslash};
			ChSlash:  r = {1'b1, ChSlash};
			ChLowN:   r = {1'b1, 8'h0A};
			ChLowR:   r = {1'b1, 8'h0D};
			ChLowT:   r = {1'b1, 8'h09};
			ChLowB:   r = {1'b1, 8'h08};
			ChLowF:   r = {1'b1, 8'h0C};
			default:  r = '0;
		endcase
		return r;
	endfunction

	function automatic bmp_utf8_t utf8_bmp(logic [15:0] cp);
		bmp_utf8_t r;
		r = '0;
		if (cp <= 16'h007F) begin
			r.len = 2'd1;
			r.b0  = cp[7:0];
		end else if (cp <= 16'h07FF) begin
			r.len = 2'd2;
			r.b0  = Lead2 | {3'b000, cp[10:6]};
			r.b1  = ContMark | {2'b00, cp[5:0]};
		end else begin
			r.len = 2'd3;
			r.b0  = Lead3 | {4'b0000, cp[15:12]};
			r.b1  = ContMark | {2'b00, cp[11:6]};
			r.b2  = ContMark | {2'b00, cp[5:0]};
		end
		return r;
	endfunction

	function automatic result_t mk_byte(logic [7:0] b);
		result_t r;
		r.out_byte     = b;
		r.carries_byte = 1'b1;
		r.run_last     = 1'b0;
		r.status       = ST_OK;
		return r;
	endfunction

	function automatic result_t mk_status(status_t st);
		result_t r;
		r.out_byte     = 8'h00;
		r.carries_byte = 1'b0;
		r.run_last     = 1'b1;
		r.status       = st;
		return r;
	endfunction

endpackage

// ----- hw/rtl/jsu_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the raw input bytes and the decoded results.
interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       line_end;

	modport source (output valid, output data_byte, output line_end, input ready);
	modport sink (input valid, input data_byte, input line_end, output ready);
endinterface

interface jsu_out_if;
	import jsu_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       carries_byte;
	logic       run_last;
	status_t    status;

	modport source (output valid, output out_byte, output carries_byte, output run_last,
		output status, input ready);
	modport sink (input valid, input out_byte, input carries_byte, input run_last,
		input status, output ready);
endinterface

// ----- hw/rtl/jsu_parser.sv -----
`timescale 1ns / 1ps
// Parser state and single-pass decode of one byte into its list of results.
module jsu_parser (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     advance,
	input  logic [7:0]               data_byte,
	input  logic                     line_end,
	output jsu_pkg::result_list_t    results,
	output logic [jsu_pkg::CntW-1:0] res_cnt
);
	import jsu_pkg::*;

	mode_t       mode_q, mode_n;
	logic [15:0] accum_q, accum_n;
	logic [2:0]  digits_q, digits_n;
	logic [9:0]  pending_q, pending_n;
	logic        fin_q, fin_n;

	logic [4:0]  hx;
	logic [8:0]  esc;
	logic [15:0] acc_new;
	logic [2:0]  dig_new;
	logic        dig_last;
	logic        is_high;
	logic        is_low;
	logic        mismatch;
	logic [20:0] pair_cp;
	bmp_utf8_t   bmp;

	logic        bmp_en;
	logic [15:0] bmp_cp;
	logic        str_en;
	logic        esc_en;
	logic        pair_en;
	logic        stat_en;
	status_t     stat_code;
	logic        hstat;

	assign hx       = hex_digit(data_byte);
	assign esc      = esc_char(data_byte);
	assign acc_new  = {accum_q[11:0], hx[3:0]};
	assign dig_new  = digits_q + 3'd1;
	assign dig_last = (digits_q == 3'd3);
	assign is_high  = (acc_new >= SurHighLo) && (acc_new <= SurHighHi);
	assign is_low   = (acc_new >= SurLowLo) && (acc_new <= SurLowHi);
	// A second escape after a high surrogate must start with D and then C..F.
	assign mismatch = ((digits_q == 3'd0) && (hx[3:0] != 4'hD)) ||
		((digits_q == 3'd1) && (hx[3:0] < 4'hC));
	assign pair_cp  = SuppBase + {1'b0, pending_q, acc_new[9:0]};
	assign bmp      = utf8_bmp(bmp_cp);

	// What the current byte does in the current mode.
	always_comb begin
		bmp_en    = 1'b0;
		bmp_cp    = ReplChar;
		str_en    = 1'b0;
		esc_en    = 1'b0;
		pair_en   = 1'b0;
		stat_en   = 1'b0;
		stat_code = ST_OK;
		unique case (mode_q)
			M_STR: begin
				str_en = 1'b1;
			end
			M_ESC: begin
				esc_en = 1'b1;
			end
			M_HEX: begin
				if (!hx[4]) begin
					stat_en   = 1'b1;
					stat_code = ST_BAD_ESCAPE;
				end else if (dig_last) begin
					if (is_low) begin
						bmp_en = 1'b1;
					end else if (!is_high) begin
						bmp_en = 1'b1;
						bmp_cp = acc_new;
					end
				end
			end
			M_PAIR_BS: begin
				if (data_byte != ChBslash) begin
					bmp_en = 1'b1;
					str_en = 1'b1;
				end
			end
			M_PAIR_U: begin
				if (data_byte != ChLowU) begin
					bmp_en = 1'b1;
					esc_en = 1'b1;
				end
			end
			M_PAIR_HEX: begin
				if (!hx[4]) begin
					stat_en   = 1'b1;
					stat_code = ST_BAD_ESCAPE;
				end else if (mismatch) begin
					bmp_en = 1'b1;
				end else if (dig_last) begin
					pair_en = 1'b1;
				end
			end
			default: begin
				if (data_byte != ChQuote) begin
					stat_en   = 1'b1;
					stat_code = ST_NOT_STRING;
				end
			end
		endcase
	end

	// Builds the ordered result list for the byte.
	always_comb begin
		results = '0;
		res_cnt = '0;
		hstat   = 1'b0;
		if (!fin_q) begin
			if (bmp_en) begin
				for (int k = 0; k < 3; k++) begin
					if (k < int'(bmp.len)) begin
						unique case (k)
							0:       results[res_cnt[IdxW-1:0]] = mk_byte(bmp.b0);
							1:       results[res_cnt[IdxW-1:0]] = mk_byte(bmp.b1);
							default: results[res_cnt[IdxW-1:0]] = mk_byte(bmp.b2);
						endcase
						res_cnt = res_cnt + CntW'(1);
					end
				end
			end
			if (str_en) begin
				if (data_byte == ChQuote) begin
					results[res_cnt[IdxW-1:0]] = mk_status(ST_OK);
					res_cnt = res_cnt + CntW'(1);
					hstat   = 1'b1;
				end else if (data_byte != ChBslash) begin
					results[res_cnt[IdxW-1:0]] = mk_byte(data_byte);
					res_cnt = res_cnt + CntW'(1);
				end
			end
			if (esc_en) begin
				if (esc[8]) begin
					results[res_cnt[IdxW-1:0]] = mk_byte(esc[7:0]);
					res_cnt = res_cnt + CntW'(1);
				end else if (data_byte != ChLowU) begin
					results[res_cnt[IdxW-1:0]] = mk_status(ST_BAD_ESCAPE);
					res_cnt = res_cnt + CntW'(1);
					hstat   = 1'b1;
				end
			end
			if (pair_en) begin
				results[0] = mk_byte(Lead4 | {5'b00000, pair_cp[20:18]});
				results[1] = mk_byte(ContMark | {2'b00, pair_cp[17:12]});
				results[2] = mk_byte(ContMark | {2'b00, pair_cp[11:6]});
				results[3] = mk_byte(ContMark | {2'b00, pair_cp[5:0]});
				res_cnt    = CntW'(4);
			end
			if (stat_en) begin
				results[res_cnt[IdxW-1:0]] = mk_status(stat_code);
				res_cnt = res_cnt + CntW'(1);
				hstat   = 1'b1;
			end
			if (line_end && !hstat) begin
				results[res_cnt[IdxW-1:0]] = mk_status(ST_UNCLOSED);
				res_cnt = res_cnt + CntW'(1);
			end
		end
	end

	// Next parser state.
	always_comb begin
		mode_n    = mode_q;
		accum_n   = accum_q;
		digits_n  = digits_q;
		pending_n = pending_q;
		fin_n     = fin_q;
		if (line_end) begin
			mode_n    = M_EXPECT;
			accum_n   = '0;
			digits_n  = '0;
			pending_n = '0;
			fin_n     = 1'b0;
		end else if (!fin_q) begin
			fin_n = hstat;
			unique case (mode_q)
				M_STR: begin
					if (data_byte == ChBslash) begin
						mode_n = M_ESC;
					end
				end
				M_ESC: begin
					mode_n = M_STR;
					if (data_byte == ChLowU) begin
						accum_n  = '0;
						digits_n = '0;
						mode_n   = M_HEX;
					end
				end
				M_HEX: begin
					if (hx[4]) begin
						accum_n  = acc_new;
						digits_n = dig_new;
						if (dig_last) begin
							digits_n = '0;
							if (is_high) begin
								pending_n = acc_new[9:0];
								mode_n    = M_PAIR_BS;
							end else begin
								mode_n = M_STR;
							end
						end
					end
				end
				M_PAIR_BS: begin
					mode_n = (data_byte == ChBslash) ? M_PAIR_U : M_STR;
				end
				M_PAIR_U: begin
					mode_n = M_STR;
					if (data_byte == ChLowU) begin
						accum_n  = '0;
						digits_n = '0;
						mode_n   = M_PAIR_HEX;
					end
				end
				M_PAIR_HEX: begin
					if (hx[4]) begin
						accum_n  = acc_new;
						digits_n = dig_new;
						if (mismatch) begin
							mode_n = M_HEX;
						end else if (dig_last) begin
							digits_n = '0;
							mode_n   = M_STR;
						end
					end
				end
				default: begin
					if (data_byte == ChQuote) begin
						mode_n = M_STR;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= M_EXPECT;
			accum_q   <= '0;
			digits_q  <= '0;
			pending_q <= '0;
			fin_q     <= 1'b0;
		end else if (advance) begin
			mode_q    <= mode_n;
			accum_q   <= accum_n;
			digits_q  <= digits_n;
			pending_q <= pending_n;
			fin_q     <= fin_n;
		end
	end

endmodule

// ----- hw/rtl/jsu_result_buf.sv -----
`timescale 1ns / 1ps
// Result register that holds one byte's result list and hands it out one per transaction.
module jsu_result_buf (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  jsu_pkg::result_list_t    results,
	input  logic [jsu_pkg::CntW-1:0] res_cnt,
	output logic                     free,
	jsu_out_if.source                out_ch
);
	import jsu_pkg::*;

	result_list_t    items_q;
	logic [CntW-1:0] cnt_q;
	logic [IdxW-1:0] idx_q;
	logic            is_last;
	result_t         cur;

	assign cur     = items_q[idx_q];
	assign is_last = (CntW'(idx_q) + CntW'(1)) == cnt_q;
	// The list can be replaced in the same cycle its last entry is taken.
	assign free    = (cnt_q == '0) || (out_ch.ready && is_last);

	assign out_ch.valid        = (cnt_q != '0);
	assign out_ch.out_byte     = cur.out_byte;
	assign out_ch.carries_byte = cur.carries_byte;
	assign out_ch.run_last     = cur.run_last;
	assign out_ch.status       = cur.status;

	always_ff @(posedge clk) begin
		if (load) begin
			items_q <= results;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= res_cnt;
			idx_q <= '0;
		end else if (out_ch.valid && out_ch.ready) begin
			if (is_last) begin
				cnt_q <= '0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + IdxW'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/json_string_unescape_utf8.sv -----
`timescale 1ns / 1ps
// Top level of the JSON string unescaper with UTF-8 output.
// A byte accepted into the input register is decoded there by the parser, and its results
// are loaded into the result register once that register is free, and are offered from it.
// Throughput: one input byte per cycle while each byte yields at most one result and out_ch is
// not stalled; a byte that yields n results holds the output register for n transactions (up to five).
// Reset: arst_n clears the parser to wait for an opening quote and empties both registers.
module json_string_unescape_utf8 (
	input  logic    clk,
	input  logic    arst_n,
	jsu_in_if.sink  in_ch,
	jsu_out_if.source out_ch
);
	import jsu_pkg::*;

	logic            valid_s1;
	logic [7:0]      data_byte_s1;
	logic            line_end_s1;
	logic            advance;
	logic            buf_free;
	result_list_t    results;
	logic [CntW-1:0] res_cnt;

	assign advance     = valid_s1 && buf_free;
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			data_byte_s1 <= in_ch.data_byte;
			line_end_s1  <= in_ch.line_end;
		end
	end

	jsu_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.data_byte (data_byte_s1),
		.line_end  (line_end_s1),
		.results   (results),
		.res_cnt   (res_cnt)
	);

	jsu_result_buf u_result_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (advance),
		.results (results),
		.res_cnt (res_cnt),
		.free    (buf_free),
		.out_ch  (out_ch)
	);

endmodule

// ----- hw/rtl/jsu_checker.sv -----
`timescale 1ns / 1ps
// Port-level assertions for the JSON string unescaper and their bind to the top level.
module jsu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       carries_byte,
	input logic       run_last,
	input logic [1:0] status
);
	import jsu_pkg::*;

	logic in_fire;
	assign in_fire = in_valid && in_ready;

	// A stalled result stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
		$stable(carries_byte) && $stable(run_last) && $stable(status))
		else $error("result changed while stalled");

	// Data bytes never end a run and always report an ok status.
	a_byte_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && carries_byte |-> !run_last && (status == ST_OK))
		else $error("data byte with run_last or nonzero status");

	// A status-only result always ends the run and carries a zero byte.
	a_status_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !carries_byte |-> run_last && (out_byte == 8'h00))
		else $error("status result without run_last or with data");

	// Nothing comes out in the first cycle after reset.
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("result offered right after reset");

	// With no result waiting, an offered byte is always taken.
	a_in_ready_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && in_valid |-> in_fire)
		else $error("input stalled while no result was waiting");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_byte     (out_ch.out_byte),
	.carries_byte (out_ch.carries_byte),
	.run_last     (out_ch.run_last),
	.status       (out_ch.status)
);

// ----- bench/tb_json_string_unescape_utf8.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the JSON string unescaper, with a cycle-free predictor of its output.
module tb_json_string_unescape_utf8;
	import jsu_pkg::*;

	localparam int CycleLimit = 60000;

	logic clk = 1'b0;
	logic arst_n;

	jsu_in_if  in_ch();
	jsu_out_if out_ch();

	json_string_unescape_utf8 dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state, mirroring what the parser must hold.
	mode_t       pmode;
	logic [15:0] code_acc;
	logic [2:0]  digit_cnt;
	logic [9:0]  high_half;
	logic        run_done;

	result_t     expected_q[$];
	logic [7:0]  line_buf[$];

	int  err_cnt = 0;
	int  useful_cnt = 0;
	int  cycle_cnt = 0;
	bit  no_idle = 1'b0;
	bit  hold_req = 1'b0;
	bit  hold_done = 1'b0;
	int  hold_left = 0;
	int  stall_left = 0;

	task automatic clear_parser();
		pmode     = M_EXPECT;
		code_acc  = '0;
		digit_cnt = '0;
		high_half = '0;
		run_done  = 1'b0;
	endtask

	task automatic line_add(input logic [7:0] b);
		line_buf = {line_buf, b};
	endtask

	task automatic push_byte(input logic [7:0] b);
		result_t r;
		r.out_byte     = b;
		r.carries_byte = 1'b1;
		r.run_last     = 1'b0;
		r.status       = ST_OK;
		expected_q = {expected_q, r};
	endtask

	task automatic push_status(input status_t st);
		result_t r;
		r.out_byte     = 8'h00;
		r.carries_byte = 1'b0;
		r.run_last     = 1'b1;
		r.status       = st;
		expected_q = {expected_q, r};
		run_done = 1'b1;
	endtask

	task automatic push_bmp(input logic [15:0] cp);
		if (cp <= 16'h007F) begin
			push_byte(cp[7:0]);
		end else if (cp <= 16'h07FF) begin
			push_byte({3'b110, cp[10:6]});
			push_byte({2'b10, cp[5:0]});
		end else begin
			push_byte({4'b1110, cp[15:12]});
			push_byte({2'b10, cp[11:6]});
			push_byte({2'b10, cp[5:0]});
		end
	endtask

	// Returns {is_hex, value}.
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [7:0] t;
		t = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30;
			return {1'b1, t[3:0]};
		end
		if (c >= 8'h61 && c <= 8'h66) begin
			t = c - 8'h57;
			return {1'b1, t[3:0]};
		end
		if (c >= 8'h41 && c <= 8'h46) begin
			t = c - 8'h37;
			return {1'b1, t[3:0]};
		end
		return 5'd0;
	endfunction

	task automatic string_byte(input logic [7:0] c);
		if (c == ChBslash) begin
			pmode = M_ESC;
		end else if (c == ChQuote) begin
			push_status(ST_OK);
		end else begin
			push_byte(c);
		end
	endtask

	task automatic escape_byte(input logic [7:0] c);
		pmode = M_STR;
		case (c)
			ChQuote, ChBslash, ChSlash: push_byte(c);
			ChLowN: push_byte(8'h0A);
			ChLowR: push_byte(8'h0D);
			ChLowT: push_byte(8'h09);
			ChLowB: push_byte(8'h08);
			ChLowF: push_byte(8'h0C);
			ChLowU: begin
				code_acc  = '0;
				digit_cnt = '0;
				pmode     = M_HEX;
			end
			default: push_status(ST_BAD_ESCAPE);
		endcase
	endtask

	task automatic parse_byte(input logic [7:0] c);
		logic [4:0]  hd;
		logic [20:0] cp;
		hd = hex_val(c);
		case (pmode)
			M_STR: string_byte(c);
			M_ESC: escape_byte(c);
			M_HEX: begin
				if (!hd[4]) begin
					push_status(ST_BAD_ESCAPE);
				end else begin
					code_acc  = {code_acc[11:0], hd[3:0]};
					digit_cnt = digit_cnt + 3'd1;
					if (digit_cnt >= 3'd4) begin
						digit_cnt = '0;
						pmode     = M_STR;
						if (code_acc >= 16'hD800 && code_acc <= 16'hDBFF) begin
							high_half = code_acc[9:0];
							pmode     = M_PAIR_BS;
						end else if (code_acc >= 16'hDC00 && code_acc <= 16'hDFFF) begin
							push_bmp(16'hFFFD);
						end else begin
							push_bmp(code_acc);
						end
					end
				end
			end
			M_PAIR_BS: begin
				if (c == ChBslash) begin
					pmode = M_PAIR_U;
				end else begin
					push_bmp(16'hFFFD);
					pmode = M_STR;
					string_byte(c);
				end
			end
			M_PAIR_U: begin
				if (c == ChLowU) begin
					code_acc  = '0;
					digit_cnt = '0;
					pmode     = M_PAIR_HEX;
				end else begin
					push_bmp(16'hFFFD);
					escape_byte(c);
				end
			end
			M_PAIR_HEX: begin
				if (!hd[4]) begin
					push_status(ST_BAD_ESCAPE);
				end else begin
					code_acc  = {code_acc[11:0], hd[3:0]};
					digit_cnt = digit_cnt + 3'd1;
					// The second escape is not a low surrogate: the high one is replaced and
					// the digits seen so far continue as a fresh escape.
					if ((digit_cnt == 3'd1 && hd[3:0] != 4'hD) ||
							(digit_cnt == 3'd2 && hd[3:0] < 4'hC)) begin
						push_bmp(16'hFFFD);
						pmode = M_HEX;
					end else if (digit_cnt >= 3'd4) begin
						cp = 21'h10000 + {1'b0, high_half, 10'b0} + {11'b0, code_acc[9:0]};
						push_byte({5'b11110, cp[20:18]});
						push_byte({2'b10, cp[17:12]});
						push_byte({2'b10, cp[11:6]});
						push_byte({2'b10, cp[5:0]});
						digit_cnt = '0;
						pmode     = M_STR;
					end
				end
			end
			default: begin
				if (c == ChQuote) begin
					pmode = M_STR;
				end else begin
					push_status(ST_NOT_STRING);
				end
			end
		endcase
	endtask

	task automatic predict_item(input logic [7:0] c, input logic last);
		if (!run_done) begin
			parse_byte(c);
			if (last && !run_done) begin
				push_status(ST_UNCLOSED);
			end
		end
		if (last) begin
			clear_parser();
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		err_cnt++;
		$display("%0t: %s mismatch, got %0h, want %0h", $time, what, got, want);
	endtask

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_byte(input logic [7:0] b, input logic last);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.line_end  <= last;
		do begin
			@(posedge clk);
		end while (!in_ch.ready);
		if (!run_done) begin
			useful_cnt++;
		end
		predict_item(b, last);
		@(negedge clk);
	endtask

	task automatic send_line();
		int i;
		for (i = 0; i < line_buf.size(); i++) begin
			send_byte(line_buf[i], i == line_buf.size() - 1);
		end
		line_buf.delete();
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) begin
			return 8'h30 + {4'h0, v};
		end
		if ($urandom_range(0, 1) == 1) begin
			return 8'h41 + {4'h0, v} - 8'd10;
		end
		return 8'h61 + {4'h0, v} - 8'd10;
	endfunction

	task automatic add_u_escape(input logic [15:0] cp);
		line_add(ChBslash);
		line_add(ChLowU);
		line_add(hex_char(cp[15:12]));
		line_add(hex_char(cp[11:8]));
		line_add(hex_char(cp[7:4]));
		line_add(hex_char(cp[3:0]));
	endtask

	function automatic logic [7:0] simple_escape(input int unsigned i);
		case (i)
			0: return ChQuote;
			1: return ChBslash;
			2: return ChSlash;
			3: return ChLowN;
			4: return ChLowR;
			5: return ChLowT;
			6: return ChLowB;
			default: return ChLowF;
		endcase
	endfunction

	function automatic bit is_escape_letter(input logic [7:0] c);
		int unsigned i;
		for (i = 0; i < 8; i++) begin
			if (c == simple_escape(i)) begin
				return 1'b1;
			end
		end
		return c == ChLowU;
	endfunction

	task automatic add_token();
		logic [7:0]  b;
		logic [15:0] cp;
		case ($urandom_range(0, 7))
			0, 1: begin
				b = 8'($urandom_range(0, 255));
				if (b == ChQuote || b == ChBslash) begin
					b = b ^ 8'h80;
				end
				line_add(b);
			end
			2: begin
				line_add(ChBslash);
				line_add(simple_escape($urandom_range(0, 7)));
			end
			3: add_u_escape(16'($urandom_range(0, 16'hFFFF)));
			4: add_u_escape(16'($urandom_range(0, 16'h07FF)));
			5: begin
				add_u_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
				add_u_escape(16'($urandom_range(16'hDC00, 16'hDFFF)));
			end
			6: add_u_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
			default: begin
				cp = 16'($urandom_range(16'hDC00, 16'hDFFF));
				add_u_escape(cp);
			end
		endcase
	endtask

	// Mostly well-formed strings with random content, the rest broken in various ways.
	task automatic build_line();
		int         kind;
		int         k;
		logic [7:0] b;
		logic [4:0] hd;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			b = 8'($urandom_range(0, 255));
			if (b == ChQuote) begin
				b = 8'h7B;
			end
			line_add(b);
			repeat ($urandom_range(0, 2)) line_add(8'($urandom_range(0, 255)));
		end else begin
			line_add(ChQuote);
			repeat ($urandom_range(0, 5)) add_token();
			case (kind)
				1: begin
					do begin
						b = 8'($urandom_range(0, 255));
					end while (is_escape_letter(b));
					line_add(ChBslash);
					line_add(b);
					repeat ($urandom_range(0, 2)) line_add(8'($urandom_range(0, 255)));
				end
				2: begin
					line_add(ChBslash);
					line_add(ChLowU);
					repeat ($urandom_range(0, 3)) line_add(hex_char(4'($urandom_range(0, 15))));
					do begin
						b  = 8'($urandom_range(0, 255));
						hd = hex_val(b);
					end while (hd[4]);
					line_add(b);
				end
				3: begin
					k = $urandom_range(0, 2);
					if (k >= 1) begin
						line_add(ChBslash);
					end
					if (k == 2) begin
						line_add(ChLowU);
						repeat ($urandom_range(0, 3)) line_add(hex_char(4'($urandom_range(0, 15))));
					end
				end
				default: begin
					line_add(ChQuote);
					repeat ($urandom_range(0, 2)) line_add(8'($urandom_range(0, 255)));
				end
			endcase
		end
	endtask

	task automatic test_not_a_string();
		line_add(8'h00);
		send_line();
	endtask

	task automatic test_extreme_bytes_and_pair();
		// Top byte passes through, U+10FFFF from a pair, then a byte ignored after the quote.
		line_add(ChQuote);
		line_add(8'hFF);
		add_u_escape(16'hDBFF);
		add_u_escape(16'hDFFF);
		line_add(ChQuote);
		line_add(8'h7A);
		send_line();
	endtask

	task automatic test_bad_escape();
		line_add(ChQuote);
		line_add(ChBslash);
		line_add(8'h71);
		line_add(8'h78);
		send_line();
	endtask

	task automatic test_lone_low_and_cut_escape();
		line_add(ChQuote);
		add_u_escape(16'hDC00);
		line_add(ChBslash);
		line_add(ChLowU);
		send_line();
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		line_add(ChQuote);
		repeat (6) add_u_escape(16'h20AC);
		line_add(ChQuote);
		send_line();
	endtask

	task automatic test_random_lines();
		while (useful_cnt < 195) begin
			build_line();
			send_line();
		end
	endtask

	task automatic test_back_to_back();
		no_idle = 1'b1;
		while (useful_cnt < 250) begin
			build_line();
			send_line();
		end
	endtask

	// Output side: random stall bursts, plus a long hold when a test asks for one.
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			hold_left = 120;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 2);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result", 32'({out_ch.out_byte, out_ch.carries_byte,
					out_ch.run_last, out_ch.status}), 32'd0);
			end else begin
				want = expected_q.pop_front();
				if (out_ch.out_byte !== want.out_byte) begin
					report_mismatch("out_byte", 32'(out_ch.out_byte), 32'(want.out_byte));
				end
				if (out_ch.carries_byte !== want.carries_byte) begin
					report_mismatch("carries_byte", 32'(out_ch.carries_byte),
						32'(want.carries_byte));
				end
				if (out_ch.run_last !== want.run_last) begin
					report_mismatch("run_last", 32'(out_ch.run_last), 32'(want.run_last));
				end
				if (out_ch.status !== want.status) begin
					report_mismatch("status", 32'(out_ch.status), 32'(want.status));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CycleLimit) begin
			$display("tb_json_string_unescape_utf8: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.data_byte = 8'h00;
		in_ch.line_end  = 1'b0;
		clear_parser();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_not_a_string();
		test_extreme_bytes_and_pair();
		test_bad_escape();
		test_lone_low_and_cut_escape();
		test_backpressure();
		test_random_lines();
		test_back_to_back();

		in_ch.valid <= 1'b0;
		while (expected_q.size() != 0) begin
			@(posedge clk);
		end
		// Anything still in flight would show up before the final result is reported.
		repeat (10) @(posedge clk);
		if (err_cnt == 0) begin
			$display("tb_json_string_unescape_utf8: done, clean");
		end else begin
			$display("tb_json_string_unescape_utf8: done, errors");
		end
		$finish;
	end

endmodule
